[rtl/epm_pkg.sv]
// ----------------------------------------------------------------------------
// epm_pkg
// Shared types, codes and constants of the entropy pool mixer.
// ----------------------------------------------------------------------------
package epm_pkg;

  localparam int CHANNELS_DEF   = 8;
  localparam int POOL_BYTES_DEF = 256;
  localparam int QUEUE_DEPTH    = 4;
  localparam int DIGEST_LEN     = 32;

  localparam int CMD_W    = 2;
  localparam int CH_W     = 3;
  localparam int BYTE_W   = 8;
  localparam int REQ_W    = 9;
  localparam int WORD_W   = 32;
  localparam int NB_W     = 3;
  localparam int SEED_W   = 2;
  localparam int INTV_W   = 20;
  localparam int TICK_W   = 21;
  localparam int CFG_AW   = 1;
  localparam int CFG_DW   = 20;
  localparam int BLK_W    = 256;

  localparam logic [CMD_W-1:0] CMD_MIX     = 2'd0;
  localparam logic [CMD_W-1:0] CMD_EXTRACT = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TICK    = 2'd2;
  localparam logic [CMD_W-1:0] CMD_STIR    = 2'd3;

  localparam logic [CFG_AW-1:0] CFG_STIR_INTERVAL = 1'b0;
  localparam logic [CFG_AW-1:0] CFG_SEED_CHANNEL  = 1'b1;

  localparam logic [SEED_W-1:0] SEED_FULL    = 2'd0;
  localparam logic [SEED_W-1:0] SEED_EMPTY   = 2'd1;
  localparam logic [SEED_W-1:0] SEED_PARTIAL = 2'd2;

  localparam logic [INTV_W-1:0] INTV_RESET = 20'd1000;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [CH_W-1:0]   channel;
    logic [BYTE_W-1:0] data_byte;
    logic [REQ_W-1:0]  request_size;
  } epm_in_t;

  typedef struct packed {
    logic [WORD_W-1:0] out_word;
    logic [NB_W-1:0]   out_bytes;
    logic              last;
    logic              stir_ready;
    logic [SEED_W-1:0] seed_status;
  } epm_out_t;

  typedef enum logic [2:0] {
    K_MIX,
    K_SKIP,
    K_EXTRACT,
    K_TICK,
    K_STIR
  } epm_kind_t;

  typedef struct packed {
    epm_kind_t         kind;
    logic [CH_W-1:0]   channel;
    logic [BYTE_W-1:0] data_byte;
    logic [REQ_W-1:0]  request_size;
    logic [REQ_W-1:0]  ext_size;
  } epm_op_t;

  typedef struct packed {
    logic    valid;
    epm_op_t op;
  } epm_head_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MIX_WR,
    ST_LOAD,
    ST_HASH,
    ST_WB,
    ST_TRD,
    ST_TCP,
    ST_MXW,
    ST_OFETCH,
    ST_OCAP,
    ST_OSTAT
  } epm_state_t;

  localparam logic [31:0] SHA_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] SHA_H0 [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

endpackage

[rtl/epm_ram.sv]
// ----------------------------------------------------------------------------
// epm_ram
// Generic memory, one write port and one read port with registered data.
// ----------------------------------------------------------------------------
module epm_ram
  import epm_pkg::*;
#(
  parameter int WIDTH = BYTE_W,
  parameter int DEPTH = POOL_BYTES_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

[rtl/epm_front.sv]
// ----------------------------------------------------------------------------
// epm_front
// Accepts input words, decodes them into operations and queues them.
// ----------------------------------------------------------------------------
module epm_front
  import epm_pkg::*;
#(
  parameter int CHANNELS   = CHANNELS_DEF,
  parameter int POOL_BYTES = POOL_BYTES_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  epm_in_t   in_data,
  input  logic      hold,
  output epm_head_t head,
  input  logic      pop
);

  localparam int QAW = $clog2(QUEUE_DEPTH);

  epm_op_t        q_r [QUEUE_DEPTH];
  logic [QAW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [QAW:0]   cnt_r, cnt_nxt;
  epm_op_t        dec;
  logic           push;

  always_comb begin
    dec.channel      = in_data.channel;
    dec.data_byte    = in_data.data_byte;
    dec.request_size = in_data.request_size;
    dec.ext_size     = (32'(in_data.request_size) > POOL_BYTES) ?
                       REQ_W'(POOL_BYTES) : in_data.request_size;
    unique case (in_data.cmd)
      CMD_MIX:     dec.kind = (32'(in_data.channel) < CHANNELS) ? K_MIX : K_SKIP;
      CMD_EXTRACT: dec.kind = K_EXTRACT;
      CMD_TICK:    dec.kind = K_TICK;
      CMD_STIR:    dec.kind = K_STIR;
      default:     dec.kind = K_SKIP;
    endcase
  end

  assign in_ready = (32'(cnt_r) < QUEUE_DEPTH) && !hold;
  assign push     = in_valid && in_ready;

  always_comb begin
    wp_nxt  = push ? wp_r + 1'b1 : wp_r;
    rp_nxt  = pop ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r + {{QAW{1'b0}}, push} - {{QAW{1'b0}}, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= dec;
    end
  end

  assign head.valid = (cnt_r != '0);
  assign head.op    = q_r[rp_r];

endmodule

[rtl/epm_sha.sv]
// ----------------------------------------------------------------------------
// epm_sha
// Iterative SHA-256 of one 32-byte message, one round per cycle.
// ----------------------------------------------------------------------------
module epm_sha
  import epm_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [BLK_W-1:0] blk,
  output logic             done,
  output logic [BLK_W-1:0] dig
);

  logic [31:0] a_r, b_r, c_r, d_r, e_r, f_r, g_r, h_r;
  logic [31:0] win_r [16];
  logic [5:0]  rnd_r;
  logic        run_r, done_r;
  logic [31:0] t1, t2, wnew;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  always_comb begin
    t1 = h_r + (rotr(e_r, 6) ^ rotr(e_r, 11) ^ rotr(e_r, 25)) +
         ((e_r & f_r) ^ (~e_r & g_r)) + SHA_K[rnd_r] + win_r[0];
    t2 = (rotr(a_r, 2) ^ rotr(a_r, 13) ^ rotr(a_r, 22)) +
         ((a_r & b_r) ^ (a_r & c_r) ^ (b_r & c_r));
    wnew = (rotr(win_r[14], 17) ^ rotr(win_r[14], 19) ^ (win_r[14] >> 10)) +
           win_r[9] +
           (rotr(win_r[1], 7) ^ rotr(win_r[1], 18) ^ (win_r[1] >> 3)) +
           win_r[0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      rnd_r  <= '0;
    end else if (start) begin
      run_r  <= 1'b1;
      done_r <= 1'b0;
      rnd_r  <= '0;
    end else if (run_r) begin
      rnd_r <= rnd_r + 1'b1;
      if (rnd_r == 6'd63) begin
        run_r  <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r <= SHA_H0[0]; b_r <= SHA_H0[1]; c_r <= SHA_H0[2]; d_r <= SHA_H0[3];
      e_r <= SHA_H0[4]; f_r <= SHA_H0[5]; g_r <= SHA_H0[6]; h_r <= SHA_H0[7];
      for (int i = 0; i < 8; i++) begin
        win_r[i] <= blk[BLK_W-1-32*i -: 32];
      end
      // padding of a single 256-bit message
      win_r[8]  <= 32'h8000_0000;
      for (int i = 9; i < 15; i++) begin
        win_r[i] <= '0;
      end
      win_r[15] <= 32'd256;
    end else if (run_r) begin
      h_r <= g_r; g_r <= f_r; f_r <= e_r; e_r <= d_r + t1;
      d_r <= c_r; c_r <= b_r; b_r <= a_r; a_r <= t1 + t2;
      for (int i = 0; i < 15; i++) begin
        win_r[i] <= win_r[i+1];
      end
      win_r[15] <= wnew;
    end
  end

  assign done = done_r;
  assign dig  = {SHA_H0[0] + a_r, SHA_H0[1] + b_r, SHA_H0[2] + c_r, SHA_H0[3] + d_r,
                 SHA_H0[4] + e_r, SHA_H0[5] + f_r, SHA_H0[6] + g_r, SHA_H0[7] + h_r};

endmodule

[rtl/epm_back.sv]
// ----------------------------------------------------------------------------
// epm_back
// Executes queued operations on the pool, notes stir requests and drives results.
// ----------------------------------------------------------------------------
module epm_back
  import epm_pkg::*;
#(
  parameter int CHANNELS   = CHANNELS_DEF,
  parameter int POOL_BYTES = POOL_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [CFG_DW-1:0] cfg_wdata,
  input  epm_head_t         head,
  output logic              pop,
  output logic              clearing,
  output logic              out_valid,
  input  logic              out_ready,
  output epm_out_t          out_data
);

  localparam int CHW     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int OFFW    = $clog2(POOL_BYTES);
  localparam int CNTW    = $clog2(POOL_BYTES + 1);
  localparam int AW      = $clog2(CHANNELS * POOL_BYTES);
  localparam int DIG_END = (POOL_BYTES / DIGEST_LEN) * DIGEST_LEN;
  localparam logic [AW-1:0] LAST_ADDR = AW'(CHANNELS * POOL_BYTES - 1);

  epm_state_t         state_r, state_nxt;
  logic [AW-1:0]      clr_r, clr_nxt;
  epm_op_t            op_r, op_nxt;
  logic [AW-1:0]      mix_addr_r, mix_addr_nxt;
  logic [OFFW-1:0]    woff_r [CHANNELS];
  logic [CNTW-1:0]    cc_r [CHANNELS];
  logic [CHANNELS-1:0] cc_nz_r, cc_nz_nxt, cc_full_r, cc_full_nxt;
  logic               any_r, any_nxt, newrec_r, newrec_nxt, want_r, want_nxt;
  logic [TICK_W-1:0]  ticks_r, ticks_nxt;
  logic [INTV_W-1:0]  intv_r;
  logic [CH_W-1:0]    seed_r;
  logic [AW-1:0]      ca_r, ca_nxt;
  logic [OFFW-1:0]    i_r, i_nxt, o_r, o_nxt, j_r, j_nxt, i_inc;
  logic [5:0]         k_r, k_nxt;
  logic [BLK_W-1:0]   blk_r, blk_nxt, dig_r, dig_nxt;
  logic [BYTE_W-1:0]  byte_r, byte_nxt;
  logic [WORD_W-1:0]  word_r, word_nxt, wv;
  logic               out_valid_r;
  epm_out_t           out_data_r;

  logic               ch_we;
  logic [CHW-1:0]     chi, qchi, seedi;
  logic [OFFW-1:0]    woff_nxt;
  logic [CNTW-1:0]    cc_nxt, off1;
  logic               slot_free, emit, jlast, need;
  logic [WORD_W-1:0]  emit_word;
  logic [NB_W-1:0]    emit_bytes;
  logic [1:0]         lane;
  epm_out_t           emit_data;

  logic               pool_we;
  logic [AW-1:0]      pool_waddr, pool_raddr;
  logic [BYTE_W-1:0]  pool_wdata, pool_rdata;
  logic               mixb_we;
  logic [OFFW-1:0]    mixb_waddr, mixb_raddr;
  logic [BYTE_W-1:0]  mixb_wdata, mixb_rdata;
  logic               sha_start, sha_done;
  logic [BLK_W-1:0]   sha_dig;

  epm_ram #(.WIDTH(BYTE_W), .DEPTH(CHANNELS * POOL_BYTES)) u_pool (
    .clk(clk), .we(pool_we), .waddr(pool_waddr), .wdata(pool_wdata),
    .raddr(pool_raddr), .rdata(pool_rdata)
  );

  epm_ram #(.WIDTH(BYTE_W), .DEPTH(POOL_BYTES)) u_mixed (
    .clk(clk), .we(mixb_we), .waddr(mixb_waddr), .wdata(mixb_wdata),
    .raddr(mixb_raddr), .rdata(mixb_rdata)
  );

  epm_sha u_sha (
    .clk(clk), .rst_n(rst_n), .start(sha_start), .blk(blk_nxt),
    .done(sha_done), .dig(sha_dig)
  );

  assign slot_free = !out_valid_r || out_ready;
  assign chi       = CHW'(op_r.channel);
  assign qchi      = CHW'(head.op.channel);
  assign seedi     = CHW'(seed_r);
  assign clearing  = (state_r == ST_CLEAR);
  assign lane      = j_r[1:0];
  assign jlast     = (REQ_W'(j_r) == op_r.ext_size - 1'b1);
  assign i_inc     = i_r + 1'b1;

  always_comb begin
    state_nxt    = state_r;
    clr_nxt      = clr_r;
    op_nxt       = op_r;
    mix_addr_nxt = mix_addr_r;
    cc_nz_nxt    = cc_nz_r;
    cc_full_nxt  = cc_full_r;
    any_nxt      = any_r;
    newrec_nxt   = newrec_r;
    want_nxt     = want_r;
    ticks_nxt    = ticks_r;
    ca_nxt       = ca_r;
    i_nxt        = i_r;
    o_nxt        = o_r;
    j_nxt        = j_r;
    k_nxt        = k_r;
    blk_nxt      = blk_r;
    dig_nxt      = dig_r;
    byte_nxt     = byte_r;
    word_nxt     = word_r;
    ch_we        = 1'b0;
    off1         = CNTW'(woff_r[chi]) + 1'b1;
    woff_nxt     = woff_r[chi];
    cc_nxt       = cc_r[chi];
    pop          = 1'b0;
    emit         = 1'b0;
    emit_word    = '0;
    emit_bytes   = '0;
    need         = 1'b0;
    wv           = word_r;
    pool_we      = 1'b0;
    pool_waddr   = clr_r;
    pool_wdata   = '0;
    pool_raddr   = AW'(qchi) * AW'(POOL_BYTES) + AW'(woff_r[qchi]);
    mixb_we      = 1'b0;
    mixb_waddr   = o_r;
    mixb_wdata   = byte_r;
    mixb_raddr   = o_r;
    sha_start    = 1'b0;

    unique case (state_r)
      ST_CLEAR: begin
        pool_we = 1'b1;
        if (clr_r == LAST_ADDR) begin
          state_nxt = ST_IDLE;
        end else begin
          clr_nxt = clr_r + 1'b1;
        end
      end
      ST_IDLE: begin
        if (head.valid && slot_free) begin
          pop          = 1'b1;
          op_nxt       = head.op;
          mix_addr_nxt = pool_raddr;
          case (head.op.kind)
            K_MIX: begin
              state_nxt = ST_MIX_WR;
            end
            K_EXTRACT: begin
              ca_nxt    = '0;
              i_nxt     = '0;
              o_nxt     = '0;
              k_nxt     = '0;
              state_nxt = ST_LOAD;
            end
            K_TICK: begin
              if (ticks_r != '1) begin
                ticks_nxt = ticks_r + 1'b1;
              end
              emit = 1'b1;
            end
            K_STIR: begin
              want_nxt = 1'b1;
              emit     = 1'b1;
            end
            default: begin
              emit = 1'b1;
            end
          endcase
        end
      end
      ST_MIX_WR: begin
        if (slot_free) begin
          pool_we    = 1'b1;
          pool_waddr = mix_addr_r;
          pool_wdata = pool_rdata ^ op_r.data_byte;
          ch_we      = 1'b1;
          if (cc_r[chi] < off1) begin
            cc_nxt     = off1;
            newrec_nxt = 1'b1;
          end
          woff_nxt           = (32'(off1) == POOL_BYTES) ? '0 : off1[OFFW-1:0];
          cc_nz_nxt[chi]     = 1'b1;
          cc_full_nxt[chi]   = (32'(cc_nxt) == POOL_BYTES);
          any_nxt            = 1'b1;
          emit               = 1'b1;
          state_nxt          = ST_IDLE;
        end
      end
      ST_LOAD: begin
        pool_raddr = ca_r + AW'(k_r);
        if (k_r != '0) begin
          blk_nxt = {blk_r[BLK_W-BYTE_W-1:0], pool_rdata};
        end
        if (k_r == 6'(DIGEST_LEN)) begin
          sha_start = 1'b1;
          k_nxt     = '0;
          state_nxt = ST_HASH;
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end
      ST_HASH: begin
        if (sha_done) begin
          dig_nxt   = sha_dig;
          state_nxt = ST_WB;
        end
      end
      ST_WB: begin
        pool_we    = 1'b1;
        pool_waddr = ca_r;
        pool_wdata = dig_r[BLK_W-1 -: BYTE_W];
        byte_nxt   = dig_r[BLK_W-1 -: BYTE_W];
        dig_nxt    = dig_r << BYTE_W;
        state_nxt  = ST_MXW;
      end
      ST_TRD: begin
        pool_raddr = ca_r;
        state_nxt  = ST_TCP;
      end
      ST_TCP: begin
        byte_nxt  = pool_rdata;
        state_nxt = ST_MXW;
      end
      ST_MXW: begin
        if (op_r.ext_size != '0) begin
          // the first channel's leading bytes start the buffer from zero
          mixb_we    = 1'b1;
          mixb_wdata = (32'(ca_r) < 32'(op_r.ext_size)) ? byte_r : (mixb_rdata ^ byte_r);
          o_nxt      = (REQ_W'(o_r) + 1'b1 == op_r.ext_size) ? '0 : o_r + 1'b1;
        end
        if (ca_r == LAST_ADDR) begin
          any_nxt    = 1'b0;
          newrec_nxt = 1'b0;
          want_nxt   = 1'b0;
          ticks_nxt  = '0;
          j_nxt      = '0;
          state_nxt  = (op_r.ext_size == '0) ? ST_OSTAT : ST_OFETCH;
        end else begin
          ca_nxt = ca_r + 1'b1;
          if (i_r == OFFW'(POOL_BYTES - 1)) begin
            i_nxt     = '0;
            o_nxt     = '0;
            k_nxt     = '0;
            state_nxt = ST_LOAD;
          end else begin
            i_nxt = i_inc;
            if (32'(i_inc) < DIG_END) begin
              if (i_inc[4:0] == 5'd0) begin
                k_nxt     = '0;
                state_nxt = ST_LOAD;
              end else begin
                state_nxt = ST_WB;
              end
            end else begin
              state_nxt = ST_TRD;
            end
          end
        end
      end
      ST_OFETCH: begin
        mixb_raddr = j_r;
        state_nxt  = ST_OCAP;
      end
      ST_OCAP: begin
        mixb_raddr = j_r;
        wv = (lane == 2'd0) ? WORD_W'(mixb_rdata) :
             (word_r | (WORD_W'(mixb_rdata) << (BYTE_W * lane)));
        need = (lane == 2'd3) || jlast;
        if (!need || slot_free) begin
          word_nxt   = wv;
          emit       = need;
          emit_word  = wv;
          emit_bytes = NB_W'(lane) + 1'b1;
          if (jlast) begin
            state_nxt = ST_IDLE;
          end else begin
            j_nxt     = j_r + 1'b1;
            state_nxt = ST_OFETCH;
          end
        end
      end
      ST_OSTAT: begin
        if (slot_free) begin
          emit      = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    emit_data.out_word   = emit_word;
    emit_data.out_bytes  = emit_bytes;
    emit_data.last       = (state_r == ST_OCAP) ? jlast : 1'b1;
    emit_data.stir_ready = (32'(op_nxt.request_size) <= POOL_BYTES) && any_nxt &&
                           (want_nxt || newrec_nxt ||
                            (ticks_nxt >= TICK_W'(intv_r)));
    if (32'(seed_r) >= CHANNELS || !cc_nz_nxt[seedi]) begin
      emit_data.seed_status = SEED_EMPTY;
    end else if (cc_full_nxt[seedi]) begin
      emit_data.seed_status = SEED_FULL;
    end else begin
      emit_data.seed_status = SEED_PARTIAL;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      cc_nz_r     <= '0;
      cc_full_r   <= '0;
      any_r       <= 1'b0;
      newrec_r    <= 1'b0;
      want_r      <= 1'b0;
      ticks_r     <= '0;
      intv_r      <= INTV_RESET;
      seed_r      <= '0;
      out_valid_r <= 1'b0;
      for (int c = 0; c < CHANNELS; c++) begin
        woff_r[c] <= '0;
        cc_r[c]   <= '0;
      end
    end else begin
      state_r   <= state_nxt;
      clr_r     <= clr_nxt;
      cc_nz_r   <= cc_nz_nxt;
      cc_full_r <= cc_full_nxt;
      any_r     <= any_nxt;
      newrec_r  <= newrec_nxt;
      want_r    <= want_nxt;
      ticks_r   <= ticks_nxt;
      if (ch_we) begin
        woff_r[chi] <= woff_nxt;
        cc_r[chi]   <= cc_nxt;
      end
      if (cfg_we) begin
        case (cfg_addr)
          CFG_STIR_INTERVAL: intv_r <= cfg_wdata[INTV_W-1:0];
          CFG_SEED_CHANNEL:  seed_r <= cfg_wdata[CH_W-1:0];
          default: ;
        endcase
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    mix_addr_r <= mix_addr_nxt;
    ca_r       <= ca_nxt;
    i_r        <= i_nxt;
    o_r        <= o_nxt;
    j_r        <= j_nxt;
    k_r        <= k_nxt;
    blk_r      <= blk_nxt;
    dig_r      <= dig_nxt;
    byte_r     <= byte_nxt;
    word_r     <= word_nxt;
    if (emit) begin
      out_data_r <= emit_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[rtl/entropy_pool_mixer_top.sv]
// ----------------------------------------------------------------------------
// entropy_pool_mixer_top
// Multi-channel entropy pool with SHA-256 conditioning on extract.
// ----------------------------------------------------------------------------
// After reset the pool memory is swept to zero, one byte a cycle; during the
// sweep no input word is taken, while configuration writes are taken as
// ever. Input words land in a four-entry queue, so the input side keeps
// accepting while the executor works, until the queue is full. A mix byte is
// read from the pool in the idle state and written back in the mix-write
// state (the pool memory has one read and one write port); a tick, a stir
// request or a mix for an absent channel is done in the idle state alone. An
// extract runs every 32-byte block through the iterative SHA-256 core (load,
// 64 rounds, latch, then write back and fold into the mix buffer), reads and
// folds each trailing byte of a channel, then fetches each returned byte.
// Each mix, tick and stir request gives one status word; an extract gives one
// word per four bytes returned (at most POOL_BYTES), or a status word if none.
// ----------------------------------------------------------------------------
module entropy_pool_mixer_top
  import epm_pkg::*;
#(
  parameter int CHANNELS   = CHANNELS_DEF,
  parameter int POOL_BYTES = POOL_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  epm_in_t           in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output epm_out_t          out_data,
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [CFG_DW-1:0] cfg_wdata
);

  epm_head_t head;
  logic      pop;
  logic      clearing;

  epm_front #(.CHANNELS(CHANNELS), .POOL_BYTES(POOL_BYTES)) u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_data(in_data), .hold(clearing), .head(head), .pop(pop)
  );

  epm_back #(.CHANNELS(CHANNELS), .POOL_BYTES(POOL_BYTES)) u_back (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_addr(cfg_addr),
    .cfg_wdata(cfg_wdata), .head(head), .pop(pop), .clearing(clearing),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

endmodule
